// ===== design/gdrm_pkg.sv =====
package gdrm_pkg;

  // Item kinds carried on in_tuser
  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_LOAD  = 2'd1,
    FUNC_QUERY = 2'd2
  } func_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_DR2_LIMIT    = 1'b0,
    REG_REL_PT_LIMIT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  localparam int unsigned CFG_W       = 18;
  localparam int unsigned DR2_W       = 18;
  localparam int unsigned RELPT_W     = 8;
  localparam int unsigned PDG_W       = 32;
  localparam int unsigned OUT_IDX_W   = 5;
  localparam logic [DR2_W-1:0]   DR2_LIMIT_RST    = 18'd23593;
  localparam logic [RELPT_W-1:0] REL_PT_LIMIT_RST = 8'd128;

  localparam logic [PDG_W-1:0] PDG_MUON     = 32'd13;
  localparam logic [PDG_W-1:0] PDG_ANTIMUON = 32'hFFFF_FFF3;

  // Azimuth wrap in 1/512 rad: half turn and full turn (2*pi rounded)
  localparam logic signed [12:0] PHI_HALF_TURN = 13'sd1608;
  localparam logic signed [12:0] PHI_FULL_TURN = 13'sd3217;

  typedef struct packed {
    logic [1:0]  charge;
    logic [15:0] pt;
    logic [12:0] eta;
    logic [11:0] phi;
  } entry_t;

  // Scan read issued towards the distance pipe
  typedef struct packed {
    logic valid;
    logic last;
    logic skip;
  } issue_t;

  // Per-entry verdict leaving the distance pipe
  typedef struct packed {
    logic             valid;
    logic             last;
    logic             qual;
    logic [DR2_W-1:0] d2;
  } verdict_t;

endpackage

// ===== design/greedy_delta_r_muon_matcher_core.sv =====
// Greedy nearest muon matcher.
// Input stream (in_*): in_tuser selects the item kind (clear table, load muon,
// query candidate); in_tdata carries the particle code and the kinematics.
// Clear and load leave the block idle. A query whose particle code is +/-13
// scans every stored entry once through the entry RAM, one entry per cycle,
// and then yields one transfer on the result stream (out_*): the match flag
// on out_tuser and the entry index on out_tdata. Other queries are dropped.
// A muon query reads the stored entries through the single RAM read port,
// passes each through three further stages of the distance pipe, folds the
// last verdict into the best match, and then commits the result and sets the
// taken mark. With an empty table the query goes straight to the commit state.
// The block handles one item at a time; in_tready is
// high whenever no query is in flight, so a held result does not stop clear,
// load or ignored items, and a query may run while its predecessor waits.
// A finished query holds in the commit state while the output register is
// still occupied by an untaken result.
// Reset (rst_n low, synchronous) empties the table, clears every taken mark
// and restores both limits to their defaults; RAM contents stay undefined
// and are never read before being loaded.
// Configuration writes (cfg_we) land at once; issue them while idle.
module greedy_delta_r_muon_matcher_core #(
  parameter int MAX_MUONS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata: pdg_id[31:0], charge[33:32], pt[49:34], eta[62:50], phi[74:63]
  input  logic [79:0]                   in_tdata,
  // in_tuser: func[1:0]
  input  logic [1:0]                    in_tuser,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // out_tdata: muon_index[4:0]
  output logic [7:0]                    out_tdata,
  // out_tuser: matched[0]
  output logic [0:0]                    out_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [gdrm_pkg::CFG_W-1:0]    cfg_wdata
);
  import gdrm_pkg::*;

  localparam int IDX_W = $clog2(MAX_MUONS);
  localparam int CNT_W = $clog2(MAX_MUONS + 1);

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [MAX_MUONS-1:0]   taken_r, taken_nxt;
  logic [DR2_W-1:0]       dr2_limit_r, dr2_limit_nxt;
  logic [RELPT_W-1:0]     rel_pt_limit_r, rel_pt_limit_nxt;
  logic                   found_r, found_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;

  // payload registers
  logic [IDX_W-1:0]       rd_idx_r, rd_idx_nxt;
  entry_t                 cand_r, cand_nxt;
  logic [DR2_W-1:0]       best_d2_r, best_d2_nxt;
  logic [IDX_W-1:0]       best_idx_r, best_idx_nxt;
  logic                   out_matched_r, out_matched_nxt;
  logic [OUT_IDX_W-1:0]   out_idx_r, out_idx_nxt;

  entry_t                 in_entry;
  entry_t                 ram_rdata;
  logic                   ram_we;
  logic [PDG_W-1:0]       in_pdg;
  logic                   is_muon;
  issue_t                 issue;
  verdict_t               verdict;
  logic [IDX_W-1:0]       verdict_idx;

  // Unpack the input item
  assign in_pdg          = in_tdata[31:0];
  assign in_entry.charge = in_tdata[33:32];
  assign in_entry.pt     = in_tdata[49:34];
  assign in_entry.eta    = in_tdata[62:50];
  assign in_entry.phi    = in_tdata[74:63];
  assign is_muon         = (in_pdg == PDG_MUON) || (in_pdg == PDG_ANTIMUON);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_matched_r;
  assign out_tdata  = {3'd0, out_idx_r};

  gdrm_entry_ram #(
    .DEPTH (MAX_MUONS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (in_entry),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  gdrm_dist_pipe #(
    .IDX_W (IDX_W)
  ) u_dist (
    .clk          (clk),
    .rst_n        (rst_n),
    .issue        (issue),
    .issue_idx    (rd_idx_r),
    .entry        (ram_rdata),
    .cand         (cand_r),
    .dr2_limit    (dr2_limit_r),
    .rel_pt_limit (rel_pt_limit_r),
    .verdict      (verdict),
    .verdict_idx  (verdict_idx)
  );

  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    taken_nxt        = taken_r;
    dr2_limit_nxt    = dr2_limit_r;
    rel_pt_limit_nxt = rel_pt_limit_r;
    found_nxt        = found_r;
    out_tvalid_nxt   = out_tvalid_r;
    rd_idx_nxt       = rd_idx_r;
    cand_nxt         = cand_r;
    best_d2_nxt      = best_d2_r;
    best_idx_nxt     = best_idx_r;
    out_matched_nxt  = out_matched_r;
    out_idx_nxt      = out_idx_r;
    ram_we           = 1'b0;
    issue            = '0;

    // Limits: written straight from the configuration port
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DR2_LIMIT:    dr2_limit_nxt    = cfg_wdata[DR2_W-1:0];
        REG_REL_PT_LIMIT: rel_pt_limit_nxt = cfg_wdata[RELPT_W-1:0];
        default: ;
      endcase
    end

    // Release the output register once the receiver takes the result
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    // Keep the first qualifying entry with the strictly smallest distance
    if (verdict.valid && verdict.qual && (!found_r || (verdict.d2 < best_d2_r))) begin
      found_nxt    = 1'b1;
      best_d2_nxt  = verdict.d2;
      best_idx_nxt = verdict_idx;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          case (func_t'(in_tuser))
            FUNC_CLEAR: begin
              cnt_nxt   = '0;
              taken_nxt = '0;
            end
            FUNC_LOAD: begin
              // drop loads into a full table
              if (cnt_r < CNT_W'(MAX_MUONS)) begin
                ram_we                       = 1'b1;
                taken_nxt[cnt_r[IDX_W-1:0]]  = 1'b0;
                cnt_nxt                      = cnt_r + CNT_W'(1);
              end
            end
            FUNC_QUERY: begin
              if (is_muon) begin
                cand_nxt   = in_entry;
                found_nxt  = 1'b0;
                rd_idx_nxt = '0;
                state_nxt  = (cnt_r == '0) ? ST_DONE : ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        issue.valid = 1'b1;
        issue.skip  = taken_r[rd_idx_r];
        issue.last  = ((CNT_W'(rd_idx_r) + CNT_W'(1)) == cnt_r);
        if (issue.last) begin
          state_nxt = ST_DRAIN;
        end else begin
          rd_idx_nxt = rd_idx_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (verdict.valid && verdict.last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register is free, then commit
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt  = 1'b1;
          out_matched_nxt = found_r;
          out_idx_nxt     = found_r ? OUT_IDX_W'(best_idx_r) : '0;
          if (found_r) begin
            taken_nxt[best_idx_r] = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      cnt_r          <= '0;
      taken_r        <= '0;
      dr2_limit_r    <= DR2_LIMIT_RST;
      rel_pt_limit_r <= REL_PT_LIMIT_RST;
      found_r        <= 1'b0;
      out_tvalid_r   <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      cnt_r          <= cnt_nxt;
      taken_r        <= taken_nxt;
      dr2_limit_r    <= dr2_limit_nxt;
      rel_pt_limit_r <= rel_pt_limit_nxt;
      found_r        <= found_nxt;
      out_tvalid_r   <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r      <= rd_idx_nxt;
    cand_r        <= cand_nxt;
    best_d2_r     <= best_d2_nxt;
    best_idx_r    <= best_idx_nxt;
    out_matched_r <= out_matched_nxt;
    out_idx_r     <= out_idx_nxt;
  end

endmodule

// ===== design/gdrm_entry_ram.sv =====
module gdrm_entry_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  gdrm_pkg::entry_t wdata,
  input  logic [AW-1:0]    raddr,
  output gdrm_pkg::entry_t rdata
);
  import gdrm_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/gdrm_dist_pipe.sv =====
module gdrm_dist_pipe #(
  parameter int IDX_W = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gdrm_pkg::issue_t              issue,
  input  logic [IDX_W-1:0]              issue_idx,
  input  gdrm_pkg::entry_t              entry,
  input  gdrm_pkg::entry_t              cand,
  input  logic [gdrm_pkg::DR2_W-1:0]    dr2_limit,
  input  logic [gdrm_pkg::RELPT_W-1:0]  rel_pt_limit,
  output gdrm_pkg::verdict_t            verdict,
  output logic [IDX_W-1:0]              verdict_idx
);
  import gdrm_pkg::*;

  // stage 0: aligned with RAM read data
  issue_t           s0_r;
  logic [IDX_W-1:0] s0_idx_r;

  // stage A: differences
  logic                s1_valid_r, s1_last_r, s1_ok_r;
  logic [IDX_W-1:0]    s1_idx_r;
  logic signed [13:0]  s1_deta_r;
  logic signed [11:0]  s1_dphi_r;
  logic [15:0]         s1_diff_r;
  logic [15:0]         s1_ept_r;

  // stage B: products
  logic                s2_valid_r, s2_last_r, s2_ok_r;
  logic [IDX_W-1:0]    s2_idx_r;
  logic [25:0]         s2_sq_eta_r;
  logic [21:0]         s2_sq_phi_r;
  logic [23:0]         s2_lhs_r;
  logic [23:0]         s2_rhs_r;

  // stage C: verdict
  verdict_t            s3_r;
  logic [IDX_W-1:0]    s3_idx_r;

  logic signed [13:0] deta_a;
  logic signed [12:0] dphi_raw;
  logic signed [12:0] dphi_wrap;
  logic [15:0]        diff_a;
  logic signed [27:0] prod_eta;
  logic signed [23:0] prod_phi;
  logic [23:0]        rhs_b;
  logic [26:0]        d2_c;
  logic               qual_c;

  always_comb begin
    deta_a   = $signed({cand.eta[12], cand.eta}) - $signed({entry.eta[12], entry.eta});
    dphi_raw = $signed({cand.phi[11], cand.phi}) - $signed({entry.phi[11], entry.phi});
    if (dphi_raw > PHI_HALF_TURN) begin
      dphi_wrap = dphi_raw - PHI_FULL_TURN;
    end else if (dphi_raw < -PHI_HALF_TURN) begin
      dphi_wrap = dphi_raw + PHI_FULL_TURN;
    end else begin
      dphi_wrap = dphi_raw;
    end
    diff_a = (cand.pt >= entry.pt) ? (cand.pt - entry.pt) : (entry.pt - cand.pt);
  end

  always_comb begin
    prod_eta = 28'(s1_deta_r) * 28'(s1_deta_r);
    prod_phi = 24'(s1_dphi_r) * 24'(s1_dphi_r);
    rhs_b    = 24'(rel_pt_limit) * 24'(s1_ept_r);
  end

  always_comb begin
    d2_c   = 27'(s2_sq_eta_r) + 27'(s2_sq_phi_r);
    qual_c = s2_ok_r && (d2_c < 27'(dr2_limit)) && (s2_lhs_r < s2_rhs_r);
  end

  always_ff @(posedge clk) begin
    s0_idx_r    <= issue_idx;
    s1_last_r   <= s0_r.last;
    s1_idx_r    <= s0_idx_r;
    s1_ok_r     <= !s0_r.skip && (cand.charge == entry.charge);
    s1_deta_r   <= deta_a;
    s1_dphi_r   <= dphi_wrap[11:0];
    s1_diff_r   <= diff_a;
    s1_ept_r    <= entry.pt;
    s2_last_r   <= s1_last_r;
    s2_idx_r    <= s1_idx_r;
    s2_ok_r     <= s1_ok_r;
    s2_sq_eta_r <= prod_eta[25:0];
    s2_sq_phi_r <= prod_phi[21:0];
    s2_lhs_r    <= {s1_diff_r, 8'd0};
    s2_rhs_r    <= rhs_b;
    s3_r.last   <= s2_last_r;
    s3_r.qual   <= qual_c;
    s3_r.d2     <= d2_c[DR2_W-1:0];
    s3_idx_r    <= s2_idx_r;
    if (!rst_n) begin
      s0_r       <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_r.valid <= 1'b0;
    end else begin
      s0_r       <= issue;
      s1_valid_r <= s0_r.valid;
      s2_valid_r <= s1_valid_r;
      s3_r.valid <= s2_valid_r;
    end
  end

  assign verdict     = s3_r;
  assign verdict_idx = s3_idx_r;

endmodule

// ===== test/greedy_delta_r_muon_matcher_core_test.sv =====
`timescale 1ns / 1ps

module greedy_delta_r_muon_matcher_core_test;
  import gdrm_pkg::*;

  localparam int MAX_MUONS       = 32;
  localparam int FUNC_UNUSED     = 3;   // spare item kind, ignored by the block
  localparam int PDG_ELECTRON    = 11;
  localparam int PHI_MAX         = 1609;
  localparam int SETTLE_CYCLES   = 64;  // comfortably longer than a muon query takes on a full table
  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int ITEMS_PER_PHASE = 110;
  localparam int PHASES          = 8;
  localparam int N_DIRECTED      = 25;

  typedef struct packed {
    logic       matched;
    logic [4:0] muon_index;
  } match_result_t;

  // Expectation typed into the directed table, or none (predictor decides)
  typedef struct packed {
    bit            typed;
    match_result_t result;
  } typed_match_t;

  typedef struct {
    int func;
    int pdg;
    int charge;
    int pt;
    int eta;
    int phi;
    int typed;
    int matched;
    int index;
  } directed_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic [79:0]         in_tdata;
  logic [1:0]          in_tuser;
  logic                in_tvalid;
  logic                in_tready;
  logic [7:0]          out_tdata;
  logic [0:0]          out_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic                cfg_we;
  logic [0:0]          cfg_index;
  logic [CFG_W-1:0]    cfg_wdata;

  // Shadow of the muon table (updated on every accepted input transfer) and of the limits
  logic [1:0]          tbl_charge [MAX_MUONS];
  logic [15:0]         tbl_pt     [MAX_MUONS];
  logic signed [12:0]  tbl_eta    [MAX_MUONS];
  logic signed [11:0]  tbl_phi    [MAX_MUONS];
  bit                  tbl_taken  [MAX_MUONS];
  int                  tbl_count;
  logic [DR2_W-1:0]    lim_dr2;
  logic [RELPT_W-1:0]  lim_relpt;

  match_result_t       expected_matches[$];
  typed_match_t        typed_matches[$];
  int                  mismatch_count = 0;
  int                  idle_run = 0;
  bit                  steady;        // no gaps on either side while set
  bit                  hold_request;  // ask the receiver for one long hold-off

  // Directed part: extremes, every item kind and the special cases
  directed_row_t directed_rows [N_DIRECTED] = '{
    // empty table straight after reset: no match
    '{FUNC_QUERY, PDG_MUON, 1, 1600, 0, 0, 1, 0, 0},
    '{FUNC_LOAD, 0, 1, 1600, 0, 0, 0, 0, 0},
    '{FUNC_LOAD, 0, -1, 65535, 4095, 1609, 0, 0, 0},
    // zero pt entry, never matches
    '{FUNC_LOAD, 0, 1, 0, 0, 0, 0, 0, 0},
    '{FUNC_LOAD, 0, 0, 1000, -4096, -1609, 0, 0, 0},
    '{FUNC_QUERY, PDG_MUON, 1, 1600, 0, 0, 1, 1, 0},
    // entry 0 now taken, entry 2 has zero pt
    '{FUNC_QUERY, PDG_MUON, 1, 1600, 0, 0, 1, 0, 0},
    // antimuon code, phi wraps across the half turn
    '{FUNC_QUERY, PDG_ANTIMUON, -1, 65535, 4095, -1609, 1, 1, 1},
    // non-muon codes: no result
    '{FUNC_QUERY, PDG_ELECTRON, 1, 1600, 0, 0, 0, 0, 0},
    '{FUNC_QUERY, 32'h8000_0000, 1, 1600, 0, 0, 0, 0, 0},
    '{FUNC_QUERY, 32'h7FFF_FFFF, 1, 1600, 0, 0, 0, 0, 0},
    // spare kind with all ones payload: ignored
    '{FUNC_UNUSED, -1, -1, 65535, -1, -1, 0, 0, 0},
    '{FUNC_QUERY, PDG_MUON, 0, 1000, -4096, -1609, 1, 1, 3},
    '{FUNC_QUERY, PDG_ANTIMUON, 0, 1000, -4096, -1609, 1, 0, 0},
    '{FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0},
    '{FUNC_QUERY, PDG_MUON, 1, 1600, 0, 0, 1, 0, 0},
    // two entries at equal distance: lower index first
    '{FUNC_LOAD, 0, 1, 800, 10, 0, 0, 0, 0},
    '{FUNC_LOAD, 0, 1, 800, -10, 0, 0, 0, 0},
    '{FUNC_QUERY, PDG_MUON, 1, 800, 0, 0, 1, 1, 0},
    '{FUNC_QUERY, PDG_MUON, 1, 800, 0, 0, 1, 1, 1},
    // charge code -2 still compares as a charge
    '{FUNC_LOAD, 0, -2, 16, 0, 0, 0, 0, 0},
    '{FUNC_QUERY, PDG_ANTIMUON, -2, 16, 0, 0, 1, 1, 2},
    // relative pt exactly at the limit fails, one step below passes
    '{FUNC_LOAD, 0, -1, 256, 0, 0, 0, 0, 0},
    '{FUNC_QUERY, PDG_ANTIMUON, -1, 384, 0, 0, 1, 0, 0},
    '{FUNC_QUERY, PDG_ANTIMUON, -1, 383, 0, 0, 1, 1, 3}
  };

  greedy_delta_r_muon_matcher_core #(
    .MAX_MUONS(MAX_MUONS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int rand_between(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int clamp_int(input int v, input int lo, input int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  // Fold an azimuth back into the legal range of the phi field
  function automatic int wrap_phi(input int v);
    if (v > PHI_MAX) return v - 2 * PHI_MAX;
    if (v < -PHI_MAX) return v + 2 * PHI_MAX;
    return v;
  endfunction

  function automatic logic [1:0] random_charge();
    if ($urandom_range(9) == 0) return 2'b10;
    return 2'(rand_between(-1, 1));
  endfunction

  function automatic logic [31:0] muon_code();
    return ($urandom_range(1) != 0) ? PDG_MUON : PDG_ANTIMUON;
  endfunction

  // Apply one accepted item to the shadow table; return the match it causes, if any
  task automatic track_item(input logic [1:0] func, input logic [79:0] data,
                            output bit has_result, output match_result_t result);
    logic [31:0]        pdg;
    logic [1:0]         charge;
    logic [15:0]        pt;
    logic signed [12:0] eta;
    logic signed [11:0] phi;
    int                 deta, dphi, d2, diff, best_d2, best_idx;
    bit                 found;
    pdg        = data[31:0];
    charge     = data[33:32];
    pt         = data[49:34];
    eta        = data[62:50];
    phi        = data[74:63];
    has_result = 1'b0;
    result     = '0;
    found      = 1'b0;
    best_d2    = 0;
    best_idx   = 0;
    case (func)
      FUNC_CLEAR: begin
        tbl_count = 0;
        foreach (tbl_taken[k]) tbl_taken[k] = 1'b0;
      end
      FUNC_LOAD: begin
        // drop loads into a full table
        if (tbl_count < MAX_MUONS) begin
          tbl_charge[tbl_count] = charge;
          tbl_pt[tbl_count]     = pt;
          tbl_eta[tbl_count]    = eta;
          tbl_phi[tbl_count]    = phi;
          tbl_taken[tbl_count]  = 1'b0;
          tbl_count++;
        end
      end
      FUNC_QUERY: begin
        if (pdg == PDG_MUON || pdg == PDG_ANTIMUON) begin
          has_result = 1'b1;
          for (int i = 0; i < tbl_count; i++) begin
            if (tbl_taken[i] || tbl_charge[i] != charge) continue;
            deta = int'(eta) - int'(tbl_eta[i]);
            dphi = int'(phi) - int'(tbl_phi[i]);
            if (dphi > int'(PHI_HALF_TURN)) dphi -= int'(PHI_FULL_TURN);
            else if (dphi < -int'(PHI_HALF_TURN)) dphi += int'(PHI_FULL_TURN);
            d2 = deta * deta + dphi * dphi;
            if (d2 >= int'(lim_dr2)) continue;
            diff = (pt >= tbl_pt[i]) ? int'(pt) - int'(tbl_pt[i])
                                     : int'(tbl_pt[i]) - int'(pt);
            if (diff * 256 >= int'(lim_relpt) * int'(tbl_pt[i])) continue;
            // strict compare keeps the lower index on a tie
            if (!found || d2 < best_d2) begin
              found    = 1'b1;
              best_d2  = d2;
              best_idx = i;
            end
          end
          if (found) begin
            tbl_taken[best_idx] = 1'b1;
            result.matched      = 1'b1;
            result.muon_index   = best_idx[4:0];
          end
        end
      end
      default: ;
    endcase
  endtask

  // Offer one item after a random gap (none while steady) and hold it until the transfer happens
  task automatic send_item(input logic [1:0] func, input logic [31:0] pdg,
                           input logic [1:0] charge, input logic [15:0] pt,
                           input logic [12:0] eta, input logic [11:0] phi,
                           input bit typed = 1'b0, input match_result_t typed_result = '0);
    int gap;
    typed_match_t note;
    if (steady) gap = 0;
    else begin
      case ($urandom_range(99)) inside
        [0:54]:  gap = 0;
        [55:89]: gap = rand_between(1, 3);
        [90:97]: gap = rand_between(4, 10);
        default: gap = rand_between(20, 60);
      endcase
    end
    note.typed  = typed;
    note.result = typed_result;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    typed_matches = {typed_matches, note};
    in_tuser  <= func;
    in_tdata  <= {5'b0, phi, eta, pt, charge, pdg};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid, wait for every outstanding match, then let the pipe run empty
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_matches.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input cfg_reg_t index, input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= CFG_W'(value);
    if (index == REG_DR2_LIMIT) lim_dr2 = DR2_W'(value);
    else lim_relpt = RELPT_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random events: mostly clear, fill with a cluster of muons, then query near them.
  // The rest is noise: spare kinds, foreign particle codes and stray kinematics.
  task automatic run_events(input int budget);
    int         sent, pick, n_loads, n_queries, eta0, phi0, j, pt, eta, phi, gen_n;
    logic [1:0] q;
    logic [1:0] gen_q   [MAX_MUONS];
    int         gen_pt  [MAX_MUONS];
    int         gen_eta [MAX_MUONS];
    int         gen_phi [MAX_MUONS];
    sent  = 0;
    gen_n = 0;
    while (sent < budget) begin
      // keep the old table now and then, so that long runs of loads overflow it
      if ($urandom_range(99) < 85) begin
        send_item(FUNC_CLEAR, $urandom, 2'($urandom), 16'($urandom), 13'($urandom),
                  12'($urandom));
        gen_n = 0;
        sent++;
      end
      pick = $urandom_range(99);
      n_loads = (pick < 80) ? rand_between(1, 6) :
                (pick < 95) ? rand_between(7, 16) : rand_between(30, 36);
      eta0 = rand_between(-3900, 3900);
      phi0 = rand_between(-PHI_MAX, PHI_MAX);
      repeat (n_loads) begin
        q   = random_charge();
        pt  = ($urandom_range(9) == 0) ? int'($urandom_range(65535)) : rand_between(16, 3200);
        eta = clamp_int(eta0 + rand_between(-150, 150), -4096, 4095);
        phi = wrap_phi(phi0 + rand_between(-150, 150));
        send_item(FUNC_LOAD, $urandom, q, 16'(pt), 13'(eta), 12'(phi));
        sent++;
        if (gen_n < MAX_MUONS) begin
          gen_q[gen_n]   = q;
          gen_pt[gen_n]  = pt;
          gen_eta[gen_n] = eta;
          gen_phi[gen_n] = phi;
          gen_n++;
        end
      end
      n_queries = rand_between(1, n_loads + 2);
      repeat (n_queries) begin
        if (gen_n > 0 && $urandom_range(99) < 80) begin
          j   = rand_between(0, gen_n - 1);
          q   = ($urandom_range(9) == 0) ? random_charge() : gen_q[j];
          pt  = clamp_int(gen_pt[j] + rand_between(-(gen_pt[j] / 3) - 1, gen_pt[j] / 3 + 1),
                          0, 65535);
          eta = clamp_int(gen_eta[j] + rand_between(-120, 120), -4096, 4095);
          phi = wrap_phi(gen_phi[j] + rand_between(-120, 120));
          send_item(FUNC_QUERY, muon_code(), q, 16'(pt), 13'(eta), 12'(phi));
          sent++;
        end else begin
          case ($urandom_range(3))
            0: send_item(2'(FUNC_UNUSED), $urandom, 2'($urandom), 16'($urandom),
                         13'($urandom), 12'($urandom));
            1: send_item(FUNC_QUERY, $urandom, random_charge(), 16'($urandom),
                         13'($urandom), 12'(rand_between(-PHI_MAX, PHI_MAX)));
            2: send_item(FUNC_QUERY, muon_code(), random_charge(), 16'($urandom),
                         13'($urandom), 12'(rand_between(-PHI_MAX, PHI_MAX)));
            default: send_item(FUNC_QUERY, PDG_ELECTRON, random_charge(),
                               16'(rand_between(16, 3200)), 13'(eta0), 12'(phi0));
          endcase
          sent++;
        end
      end
    end
  endtask

  // Receiver: ready in runs, mostly short stalls with a few long ones, always ready while steady,
  // and one long hold-off whenever it is asked for
  initial begin : receiver
    int len;
    bit level;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (steady) begin
        out_tready <= 1'b1;
      end else begin
        level = ($urandom_range(99) < 65);
        if (level) len = rand_between(1, 8);
        else len = ($urandom_range(99) < 85) ? rand_between(1, 3) : rand_between(20, 60);
        out_tready <= level;
        repeat (len - 1) @(negedge clk);
      end
    end
  end

  // Sample both channels at the rising edge: predict on input transfers,
  // compare result transfers with the oldest expectation
  always @(posedge clk) begin : monitor
    bit            produces;
    match_result_t predicted;
    match_result_t fresh;
    match_result_t want;
    typed_match_t  note;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        track_item(in_tuser, in_tdata, produces, predicted);
        note = typed_matches.pop_front();
        if (produces) begin
          fresh            = note.typed ? note.result : predicted;
          expected_matches = {expected_matches, fresh};
        end
      end
      if (out_tvalid && out_tready) begin
        if (expected_matches.size() == 0) begin
          $error("result with no expectation: matched %0d, muon_index %0d",
                 out_tuser[0], out_tdata[4:0]);
          mismatch_count++;
        end else begin
          want = expected_matches.pop_front();
          if (out_tuser[0] !== want.matched) begin
            $error("matched: expected %0d, actual %0d", want.matched, out_tuser[0]);
            mismatch_count++;
          end
          if (out_tdata[4:0] !== want.muon_index) begin
            $error("muon_index: expected %0d, actual %0d", want.muon_index, out_tdata[4:0]);
            mismatch_count++;
          end
        end
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_run = 0;
    else idle_run++;
  end

  // End the run if no transfer happens for far longer than any correct stall
  initial begin : watchdog
    wait (idle_run >= WATCHDOG_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    directed_row_t r;
    match_result_t typed_res;
    int            dr2, relpt;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = FUNC_CLEAR;
    cfg_we       = 1'b0;
    cfg_index    = REG_DR2_LIMIT;
    cfg_wdata    = '0;
    steady       = 1'b0;
    hold_request = 1'b0;
    lim_dr2      = DR2_LIMIT_RST;
    lim_relpt    = REL_PT_LIMIT_RST;
    tbl_count    = 0;
    foreach (tbl_taken[k]) tbl_taken[k] = 1'b0;

    // hold reset low from the start, release it at a falling edge
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Directed table at the reset limits
    foreach (directed_rows[k]) begin
      r                    = directed_rows[k];
      typed_res.matched    = r.matched[0];
      typed_res.muon_index = r.index[4:0];
      send_item(2'(r.func), 32'(r.pdg), 2'(r.charge), 16'(r.pt), 13'(r.eta), 12'(r.phi),
                r.typed != 0, typed_res);
    end

    // Random phases, each under its own pair of limits, written only while idle
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      case (phase)
        0: begin dr2 = 262143; relpt = 255; end
        1: begin dr2 = 0;      relpt = 128; end
        2: begin dr2 = 23593;  relpt = 0;   end
        3: begin dr2 = 23593;  relpt = 128; end
        4: begin dr2 = $urandom_range(60000); relpt = $urandom_range(255); end
        5: begin dr2 = 262143; relpt = 1;   end
        6: begin dr2 = 1;      relpt = 255; end
        default: begin dr2 = $urandom_range(262143); relpt = $urandom_range(255); end
      endcase
      write_limit(REG_DR2_LIMIT, dr2);
      write_limit(REG_REL_PT_LIMIT, relpt);
      steady = (phase == 3);
      // back the result channel up so that queries pile up and stall the input
      if (phase == 4 || phase == 7) hold_request = 1'b1;
      run_events(ITEMS_PER_PHASE);
    end

    drain_results();
    if (mismatch_count == 0 && expected_matches.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
